/* rtl/rol_pkg.sv */
// package for the recency ordered list unit
// shared types, field widths and codes; no dependencies
`default_nettype none

package rol_pkg;

  localparam int unsigned SLOTS_DEF      = 8;
  localparam int unsigned STAMP_BITS_DEF = 32;

  // fixed field widths of the stream payload
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned ID_W       = 8;
  localparam int unsigned STAMP_W    = 32;
  localparam int unsigned POS_W      = 3;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 48;

  typedef enum logic [CMD_W-1:0] {
    CMD_TOUCH  = 2'd0,
    CMD_SETTLE = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_BAD_POS   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_IDLE,
    CELL_MATCH,
    CELL_REMOVE,
    CELL_INSERT
  } cell_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_REMOVE,
    S_INSERT,
    S_DONE
  } state_e;

  typedef struct packed {
    cell_op_e op;
    logic     settle;  // ties with the key keep the old order
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* rtl/rol_cell.sv */
// one slot of the ordered list: holds id, running flag and stamp
// trades entries with its neighbors; uses rol_pkg
`default_nettype none

module rol_cell #(
  parameter int unsigned STAMP_BITS = rol_pkg::STAMP_BITS_DEF,
  parameter int unsigned CNT_W      = 4,
  parameter int unsigned IDX        = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rol_pkg::cell_ctrl_t       ctrl_i,
  input  logic [rol_pkg::ID_W-1:0]  key_id_i,
  input  logic                      key_run_i,
  input  logic [STAMP_BITS-1:0]     key_stamp_i,
  input  logic [CNT_W-1:0]          count_i,
  input  logic [rol_pkg::ID_W-1:0]  left_id_i,
  input  logic                      left_run_i,
  input  logic [STAMP_BITS-1:0]     left_stamp_i,
  input  logic                      left_before_i,
  input  logic                      left_hit_i,
  input  logic [rol_pkg::ID_W-1:0]  right_id_i,
  input  logic                      right_run_i,
  input  logic [STAMP_BITS-1:0]     right_stamp_i,
  output logic [rol_pkg::ID_W-1:0]  id_o,
  output logic                      run_o,
  output logic [STAMP_BITS-1:0]     stamp_o,
  output logic                      before_o,
  output logic                      hit_o,
  output logic                      match_o
);
  import rol_pkg::*;

  logic [ID_W-1:0]       id_q, id_d;
  logic                  run_q, run_d;
  logic [STAMP_BITS-1:0] stamp_q, stamp_d;
  logic                  hit_q, hit_d;
  logic                  after_q, after_d;
  logic                  valid;
  logic                  own_match;
  logic                  run_ahead;
  logic                  run_same;
  logic                  stamp_ahead;
  logic                  tie_keep;

  always_comb begin
    valid       = CNT_W'(IDX) < count_i;
    own_match   = valid && (id_q == key_id_i);
    run_ahead   = run_q & ~key_run_i;
    run_same    = run_q == key_run_i;
    stamp_ahead = stamp_q > key_stamp_i;
    // on settle, entries that sat ahead of the old place win ties
    tie_keep    = ctrl_i.settle & ~after_q & (stamp_q == key_stamp_i);
    before_o    = valid & (run_ahead | (run_same & (stamp_ahead | tie_keep)));
    hit_o       = left_hit_i | hit_q;
  end

  always_comb begin
    id_d    = id_q;
    run_d   = run_q;
    stamp_d = stamp_q;
    hit_d   = hit_q;
    after_d = after_q;
    unique case (ctrl_i.op)
      CELL_MATCH: begin
        hit_d   = own_match;
        after_d = 1'b0;
      end
      CELL_REMOVE: begin
        // close the gap: everything from the hit onward pulls from the right
        after_d = hit_o;
        if (hit_o) begin
          id_d    = right_id_i;
          run_d   = right_run_i;
          stamp_d = right_stamp_i;
        end
      end
      CELL_INSERT: begin
        if (!before_o) begin
          if (left_before_i) begin
            id_d    = key_id_i;
            run_d   = key_run_i;
            stamp_d = key_stamp_i;
          end else begin
            id_d    = left_id_i;
            run_d   = left_run_i;
            stamp_d = left_stamp_i;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q   <= 1'b0;
      after_q <= 1'b0;
    end else begin
      hit_q   <= hit_d;
      after_q <= after_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q    <= id_d;
    run_q   <= run_d;
    stamp_q <= stamp_d;
  end

  assign id_o    = id_q;
  assign run_o   = run_q;
  assign stamp_o = stamp_q;
  assign match_o = hit_q;

endmodule

`default_nettype wire

/* rtl/recency_ordered_list_unit.sv */
// Recency ordered list: up to SLOTS entries kept running-first, then by larger
// stamp, in a row of rol_cell slots that shift entries to their neighbors.
// A command walks the row in phases: match, remove (close the gap), insert
// (open a gap at the sorted place), then result; a read goes from match
// straight to result, and a remove or a refused command skips insert. The
// result waits in the result phase while the output is held, and the next
// command is taken only after it has been loaded into the output register.
// No clearing pass after reset.
// Depends on rol_pkg and rol_cell.
`default_nettype none

module recency_ordered_list_unit #(
  parameter int unsigned SLOTS      = rol_pkg::SLOTS_DEF,
  parameter int unsigned STAMP_BITS = rol_pkg::STAMP_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // cmd[1:0], entry_id[9:2], is_running[10], use_stamp[42:11], position[45:43]
  input  logic [rol_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // status[1:0], found_id[9:2], found_running[10], found_stamp[42:11],
  // entry_count[46:43]
  output logic [rol_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import rol_pkg::*;

  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  state_e                state_q, state_d;
  cmd_e                  cmd_q;
  logic [ID_W-1:0]       id_q;
  logic                  run_q;
  logic [STAMP_BITS-1:0] stamp_q;
  logic [POS_W-1:0]      pos_q;
  logic [CNT_W-1:0]      count_q, count_d;
  status_e               status_q, status_d;
  logic [ID_W-1:0]       fid_q, fid_d;
  logic                  frun_q, frun_d;
  logic [STAMP_BITS-1:0] fst_q, fst_d;
  logic                  m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0] m_data_q, m_data_d;
  logic                  in_fire;
  logic                  out_load;
  logic                  pos_ok;
  logic                  full;
  logic                  any_hit;
  cell_ctrl_t            ctrl;

  logic [ID_W-1:0]       c_id    [SLOTS];
  logic                  c_run   [SLOTS];
  logic [STAMP_BITS-1:0] c_stamp [SLOTS];
  logic [SLOTS:0]        before_chain;
  logic [SLOTS:0]        hit_chain;
  logic [SLOTS-1:0]      c_match;
  logic [ID_W-1:0]       rd_id;
  logic                  rd_run;
  logic [STAMP_BITS-1:0] rd_stamp;

  assign before_chain[0] = 1'b1;
  assign hit_chain[0]    = 1'b0;
  assign any_hit         = hit_chain[SLOTS];

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    logic [ID_W-1:0]       l_id, r_id;
    logic                  l_run, r_run;
    logic [STAMP_BITS-1:0] l_stamp, r_stamp;

    if (k == 0) begin : g_first
      assign l_id    = id_q;
      assign l_run   = run_q;
      assign l_stamp = stamp_q;
    end else begin : g_inner_l
      assign l_id    = c_id[k-1];
      assign l_run   = c_run[k-1];
      assign l_stamp = c_stamp[k-1];
    end

    if (k == SLOTS - 1) begin : g_last
      assign r_id    = id_q;
      assign r_run   = run_q;
      assign r_stamp = stamp_q;
    end else begin : g_inner_r
      assign r_id    = c_id[k+1];
      assign r_run   = c_run[k+1];
      assign r_stamp = c_stamp[k+1];
    end

    rol_cell #(
      .STAMP_BITS (STAMP_BITS),
      .CNT_W      (CNT_W),
      .IDX        (k)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .key_id_i      (id_q),
      .key_run_i     (run_q),
      .key_stamp_i   (stamp_q),
      .count_i       (count_q),
      .left_id_i     (l_id),
      .left_run_i    (l_run),
      .left_stamp_i  (l_stamp),
      .left_before_i (before_chain[k]),
      .left_hit_i    (hit_chain[k]),
      .right_id_i    (r_id),
      .right_run_i   (r_run),
      .right_stamp_i (r_stamp),
      .id_o          (c_id[k]),
      .run_o         (c_run[k]),
      .stamp_o       (c_stamp[k]),
      .before_o      (before_chain[k+1]),
      .hit_o         (hit_chain[k+1]),
      .match_o       (c_match[k])
    );
  end

  // read port: and-or select of the cell at the asked position
  always_comb begin
    rd_id    = '0;
    rd_run   = 1'b0;
    rd_stamp = '0;
    for (int k = 0; k < SLOTS; k++) begin
      if (CMP_W'(pos_q) == CMP_W'(k)) begin
        rd_id    = rd_id | c_id[k];
        rd_run   = rd_run | c_run[k];
        rd_stamp = rd_stamp | c_stamp[k];
      end
    end
  end

  assign s_axis_tready = state_q == S_IDLE;
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign pos_ok        = CMP_W'(pos_q) < CMP_W'(count_q);
  assign full          = count_q == CNT_W'(SLOTS);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    status_d    = status_q;
    fid_d       = fid_q;
    frun_d      = frun_q;
    fst_d       = fst_q;
    out_load    = 1'b0;
    ctrl.op     = CELL_IDLE;
    ctrl.settle = cmd_q == CMD_SETTLE;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_MATCH;
        end
      end
      S_MATCH: begin
        ctrl.op  = CELL_MATCH;
        status_d = ST_OK;
        fid_d    = '0;
        frun_d   = 1'b0;
        fst_d    = '0;
        if (cmd_q == CMD_READ) begin
          state_d = S_DONE;
          if (pos_ok) begin
            fid_d  = rd_id;
            frun_d = rd_run;
            fst_d  = rd_stamp;
          end else begin
            status_d = ST_BAD_POS;
          end
        end else begin
          state_d = S_REMOVE;
        end
      end
      S_REMOVE: begin
        ctrl.op = CELL_REMOVE;
        state_d = S_DONE;
        unique case (cmd_q)
          CMD_TOUCH: begin
            if (any_hit) begin
              count_d = count_q - CNT_W'(1);
              state_d = S_INSERT;
            end else if (full) begin
              status_d = ST_FULL;
            end else begin
              state_d = S_INSERT;
            end
          end
          CMD_SETTLE: begin
            if (any_hit) begin
              count_d = count_q - CNT_W'(1);
              state_d = S_INSERT;
            end else begin
              status_d = ST_NOT_FOUND;
            end
          end
          CMD_REMOVE: begin
            if (any_hit) begin
              count_d = count_q - CNT_W'(1);
            end else begin
              status_d = ST_NOT_FOUND;
            end
          end
          CMD_READ: begin
          end
        endcase
      end
      S_INSERT: begin
        ctrl.op = CELL_INSERT;
        count_d = count_q + CNT_W'(1);
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (out_load) begin
      m_valid_d = 1'b1;
      m_data_d  = {{(OUT_DATA_W - STATUS_W - ID_W - 1 - STAMP_W - COUNT_W){1'b0}},
                   COUNT_W'(count_q), STAMP_W'(fst_q), frun_q, fid_q, status_q};
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q   <= cmd_e'(s_axis_tdata[1:0]);
      id_q    <= s_axis_tdata[9:2];
      run_q   <= s_axis_tdata[10];
      stamp_q <= STAMP_BITS'(s_axis_tdata[42:11]);
      pos_q   <= s_axis_tdata[45:43];
    end
    status_q <= status_d;
    fid_q    <= fid_d;
    frun_q   <= frun_d;
    fst_q    <= fst_d;
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(SLOTS))
    else $error("entry count beyond slot count");

  a_single_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_REMOVE |-> $onehot0(c_match))
    else $error("id held in more than one slot");

  a_insert_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_INSERT |=> count_q == $past(count_q + CNT_W'(1)))
    else $error("insert did not add one entry");

  a_result_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == S_DONE))
    else $error("result raised outside the result phase");

endmodule

`default_nettype wire

/* test/recency_ordered_list_unit_tb.sv */
// testbench for recency_ordered_list_unit: directed and random command streams
// checked against a behavioral copy of the ordered list; needs rol_pkg and the rtl
`timescale 1ns / 100ps

module recency_ordered_list_unit_tb;
  import rol_pkg::*;

  localparam int unsigned SLOTS = SLOTS_DEF;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     id;
    logic                running;
    logic [STAMP_W-1:0]  stamp;
    logic [COUNT_W-1:0]  count;
  } list_reply_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // cmd[1:0], entry_id[9:2], is_running[10], use_stamp[42:11], position[45:43]
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // status[1:0], found_id[9:2], found_running[10], found_stamp[42:11],
  // entry_count[46:43]
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // behavioral copy of the list
  logic [ID_W-1:0]    list_id    [SLOTS];
  logic               list_run   [SLOTS];
  logic [STAMP_W-1:0] list_stamp [SLOTS];
  int unsigned        list_count = 0;

  list_reply_t pending_replies[$];
  int          fail_count = 0;
  int          replies_checked = 0;
  int          cmd_count[4] = '{default: 0};
  int          status_count[4] = '{default: 0};
  bit          burst_mode = 1'b0;
  logic [ID_W-1:0] id_pool[12];

  recency_ordered_list_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int find_entry(logic [ID_W-1:0] id);
    for (int i = 0; i < list_count; i++)
      if (list_id[i] == id) return i;
    return -1;
  endfunction

  // stable insertion sort: an entry only moves past entries it strictly precedes
  function automatic void sort_list();
    logic [ID_W-1:0]    kid;
    logic               krun;
    logic [STAMP_W-1:0] kst;
    logic               ahead;
    int                 j;
    for (int i = 1; i < list_count; i++) begin
      kid  = list_id[i];
      krun = list_run[i];
      kst  = list_stamp[i];
      j    = i;
      while (j > 0) begin
        if (krun != list_run[j-1]) ahead = krun;
        else ahead = (kst > list_stamp[j-1]);
        if (!ahead) break;
        list_id[j]    = list_id[j-1];
        list_run[j]   = list_run[j-1];
        list_stamp[j] = list_stamp[j-1];
        j--;
      end
      list_id[j]    = kid;
      list_run[j]   = krun;
      list_stamp[j] = kst;
    end
  endfunction

  function automatic list_reply_t update_list(cmd_e c, logic [ID_W-1:0] id, logic run,
                                              logic [STAMP_W-1:0] stamp,
                                              logic [POS_W-1:0] pos);
    list_reply_t r;
    int          idx;
    r = '{status: ST_OK, id: '0, running: 1'b0, stamp: '0, count: '0};
    case (c)
      CMD_TOUCH: begin
        idx = find_entry(id);
        if (idx < 0 && list_count >= SLOTS) begin
          r.status = ST_FULL;
        end else begin
          if (idx < 0) begin
            idx = list_count;
            list_count++;
          end
          // move to front, then re-sort
          for (int k = idx; k > 0; k--) begin
            list_id[k]    = list_id[k-1];
            list_run[k]   = list_run[k-1];
            list_stamp[k] = list_stamp[k-1];
          end
          list_id[0]    = id;
          list_run[0]   = run;
          list_stamp[0] = stamp;
          sort_list();
        end
      end
      CMD_SETTLE: begin
        idx = find_entry(id);
        if (idx < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          list_run[idx]   = run;
          list_stamp[idx] = stamp;
          sort_list();
        end
      end
      CMD_REMOVE: begin
        idx = find_entry(id);
        if (idx < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          for (int k = idx; k + 1 < list_count; k++) begin
            list_id[k]    = list_id[k+1];
            list_run[k]   = list_run[k+1];
            list_stamp[k] = list_stamp[k+1];
          end
          list_count--;
        end
      end
      default: begin
        if (pos >= list_count) begin
          r.status = ST_BAD_POS;
        end else begin
          r.id      = list_id[pos];
          r.running = list_run[pos];
          r.stamp   = list_stamp[pos];
        end
      end
    endcase
    r.count = list_count[COUNT_W-1:0];
    return r;
  endfunction

  // valid stays high across back-to-back transactions; it is lowered only for a gap or to drain
  task automatic send_cmd(cmd_e c, logic [ID_W-1:0] id, logic run,
                          logic [STAMP_W-1:0] stamp, logic [POS_W-1:0] pos);
    int          gap;
    list_reply_t r;
    gap = burst_mode ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, pos, stamp, run, id, c};
    do @(posedge clk_i); while (!s_axis_tready);
    r = update_list(c, id, run, stamp, pos);
    pending_replies.push_back(r);
    cmd_count[c]++;
    status_count[r.status]++;
  endtask

  task automatic drain_replies();
    int waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    while (pending_replies.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_replies.size() != 0) begin
      $error("%0d transactions never produced a result", pending_replies.size());
      fail_count++;
    end
    repeat (10) @(posedge clk_i);
  endtask

  // result side: random stalls, compare each transaction with the oldest prediction
  initial begin
    int          stall;
    list_reply_t exp_r;
    @(posedge rst_ni);
    forever begin
      stall = burst_mode ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      if (pending_replies.size() == 0) begin
        $error("unexpected result transaction %h", m_axis_tdata);
        fail_count++;
      end else begin
        exp_r = pending_replies.pop_front();
        replies_checked++;
        if (m_axis_tdata[1:0] !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, m_axis_tdata[1:0]);
          fail_count++;
        end
        if (m_axis_tdata[9:2] !== exp_r.id) begin
          $error("found_id: expected %h, got %h", exp_r.id, m_axis_tdata[9:2]);
          fail_count++;
        end
        if (m_axis_tdata[10] !== exp_r.running) begin
          $error("found_running: expected %b, got %b", exp_r.running, m_axis_tdata[10]);
          fail_count++;
        end
        if (m_axis_tdata[42:11] !== exp_r.stamp) begin
          $error("found_stamp: expected %h, got %h", exp_r.stamp, m_axis_tdata[42:11]);
          fail_count++;
        end
        if (m_axis_tdata[46:43] !== exp_r.count) begin
          $error("entry_count: expected %0d, got %0d", exp_r.count, m_axis_tdata[46:43]);
          fail_count++;
        end
      end
    end
  end

  task automatic test_empty_list();
    send_cmd(CMD_READ, 8'h00, 1'b0, '0, 3'd0);
    send_cmd(CMD_REMOVE, 8'h12, 1'b0, '0, 3'd0);
    send_cmd(CMD_SETTLE, 8'h12, 1'b1, 32'hFFFF_FFFF, 3'd0);
  endtask

  task automatic test_fill_and_order();
    send_cmd(CMD_TOUCH, 8'h00, 1'b0, 32'h0000_0000, 3'd0);
    send_cmd(CMD_TOUCH, 8'hFF, 1'b1, 32'hFFFF_FFFF, 3'd7);
    send_cmd(CMD_TOUCH, 8'h5A, 1'b1, 32'd5, 3'd0);
    // equal key: the newer touch goes first among ties
    send_cmd(CMD_TOUCH, 8'hA5, 1'b1, 32'd5, 3'd0);
    send_cmd(CMD_TOUCH, 8'h01, 1'b0, 32'h0000_0000, 3'd0);
    send_cmd(CMD_TOUCH, 8'h80, 1'b0, 32'h8000_0000, 3'd0);
    send_cmd(CMD_TOUCH, 8'h7F, 1'b1, 32'h0000_0000, 3'd0);
    send_cmd(CMD_TOUCH, 8'h33, 1'b0, 32'd7, 3'd0);
  endtask

  task automatic test_full_list();
    send_cmd(CMD_TOUCH, 8'h44, 1'b1, 32'd9, 3'd0);
    // existing id on a full list is still accepted
    send_cmd(CMD_TOUCH, 8'h5A, 1'b0, 32'h0000_0000, 3'd0);
  endtask

  task automatic test_settle_ties();
    // settle keeps the previous order among equal keys
    send_cmd(CMD_SETTLE, 8'hA5, 1'b1, 32'h0000_0000, 3'd0);
    for (int p = 0; p < SLOTS; p++) send_cmd(CMD_READ, 8'h00, 1'b0, '0, p[POS_W-1:0]);
  endtask

  task automatic test_remove_and_bounds();
    send_cmd(CMD_REMOVE, 8'hFF, 1'b0, '0, 3'd0);
    send_cmd(CMD_REMOVE, 8'h33, 1'b0, '0, 3'd0);
    send_cmd(CMD_READ, 8'h00, 1'b0, '0, 3'd7);
  endtask

  function automatic logic [STAMP_W-1:0] pick_stamp();
    case ($urandom_range(0, 3))
      0, 1:    return $urandom_range(0, 7);
      2:       return 32'hFFFF_FFF8 + $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [ID_W-1:0] pick_id(bit prefer_held);
    if (prefer_held && list_count > 0 && $urandom_range(0, 9) < 6)
      return list_id[$urandom_range(0, list_count - 1)];
    if ($urandom_range(0, 9) == 0) return ID_W'($urandom_range(0, 255));
    return id_pool[$urandom_range(0, 11)];
  endfunction

  task automatic test_random_traffic(int n_items);
    int          sel;
    logic [POS_W-1:0] pos;
    for (int n = 0; n < n_items; n++) begin
      if (n % 200 == 0)
        foreach (id_pool[k]) id_pool[k] = ID_W'($urandom_range(0, 255));
      if (n % 100 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 99);
      if (list_count > 0 && $urandom_range(0, 3) != 0)
        pos = POS_W'($urandom_range(0, list_count - 1));
      else
        pos = POS_W'($urandom_range(0, 7));
      if (sel < 35)
        send_cmd(CMD_TOUCH, pick_id(1'($urandom_range(0, 1))), 1'($urandom_range(0, 1)),
                 pick_stamp(), POS_W'($urandom_range(0, 7)));
      else if (sel < 55)
        send_cmd(CMD_SETTLE, pick_id(1'b1), 1'($urandom_range(0, 1)), pick_stamp(),
                 POS_W'($urandom_range(0, 7)));
      else if (sel < 67)
        send_cmd(CMD_REMOVE, pick_id(1'b1), 1'($urandom_range(0, 1)), $urandom, pos);
      else
        send_cmd(CMD_READ, ID_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                 $urandom, pos);
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    test_fill_and_order();
    test_full_list();
    test_settle_ties();
    test_remove_and_bounds();
    test_random_traffic(1350);
    drain_replies();
    $display("checked %0d results: touch %0d, settle %0d, remove %0d, read %0d",
             replies_checked, cmd_count[CMD_TOUCH], cmd_count[CMD_SETTLE],
             cmd_count[CMD_REMOVE], cmd_count[CMD_READ]);
    $display("status mix: ok %0d, full %0d, unknown id %0d, bad position %0d",
             status_count[ST_OK], status_count[ST_FULL], status_count[ST_NOT_FOUND],
             status_count[ST_BAD_POS]);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

/* files.f */
rtl/rol_pkg.sv
rtl/rol_cell.sv
rtl/recency_ordered_list_unit.sv
test/recency_ordered_list_unit_tb.sv
